### design/eig2_pkg.sv
// ----------------------------------------------------------------------------
// eig2_pkg
// Shared widths of the 2x2 eigenvalue pipeline result fields.
// ----------------------------------------------------------------------------
package eig2_pkg;

    localparam int W_REAL     = 19;
    localparam int W_IMAG_NEG = 18;
    localparam int W_IMAG_POS = 17;

    localparam int OUT_BITS   = 2 * W_REAL + W_IMAG_NEG + W_IMAG_POS;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [W_REAL-1:0]     real_x2_t;
    typedef logic signed [W_IMAG_NEG-1:0] imag_neg_t;
    typedef logic        [W_IMAG_POS-1:0] imag_pos_t;

endpackage

### design/eigenvalues_2x2.sv
// ----------------------------------------------------------------------------
// eigenvalues_2x2
// Closed-form eigenvalues of a 2x2 signed integer matrix, doubled.
// ----------------------------------------------------------------------------
// Accepts one matrix per clock unless backpressure from the output side
// deasserts s_tready, and returns one result beat per matrix, in order. The
// depth is set by the square root unit, which resolves one root bit per
// pipeline stage, ENTRY_WIDTH + 1 stages in all; the front end spends one
// stage each on differences, the two multipliers, the discriminant and its
// magnitude, and a final register drives the port. Every stage holds its own
// valid bit, so bubbles are squeezed out under backpressure. Results are in
// units of one half: real parts are (a+d) -/+ R and imaginary parts zero, or,
// in the complex case that m_tuser flags, real parts (a+d) and imaginary parts
// -/+ R, where R is the floor square root of |(a-d)^2+4bc|.
module eigenvalues_2x2
    import eig2_pkg::*;
#(
    parameter int ENTRY_WIDTH = 16
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // entry_a, entry_b, entry_c, entry_d
    input  logic [((4*ENTRY_WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // first_real_x2, first_imag_x2, second_real_x2, second_imag_x2
    output logic [OUT_DATA_W-1:0]                     m_tdata,
    // is_complex
    output logic                                      m_tuser
);

    localparam int EW  = ENTRY_WIDTH;
    localparam int DW  = EW + 1;
    localparam int PW  = 2 * EW + 2;
    localparam int BW  = 2 * EW;
    localparam int SW  = 2 * EW + 3;
    localparam int MW  = 2 * EW + 2;
    localparam int TW  = MW + 1;
    localparam int RW  = EW + 1;
    localparam int OW  = (EW + 3 > W_REAL) ? EW + 3 : W_REAL;

    logic signed [EW-1:0] a_in, b_in, c_in, d_in;

    assign a_in = s_tdata[EW-1:0];
    assign b_in = s_tdata[2*EW-1:EW];
    assign c_in = s_tdata[3*EW-1:2*EW];
    assign d_in = s_tdata[4*EW-1:3*EW];

    // stage valid bits and advance chain
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic va_reg [0:RW];
    logic m1, m2, m3, mo;
    logic ma [0:RW];

    assign mo = !vo_reg || m_tready;
    assign ma[RW] = !va_reg[RW] || mo;

    genvar g;
    generate
        for (g = 0; g < RW; g++)
        begin : g_move
            assign ma[g] = !va_reg[g] || ma[g+1];
        end
    endgenerate

    assign m3 = !v3_reg || ma[0];
    assign m2 = !v2_reg || m3;
    assign m1 = !v1_reg || m2;
    assign s_tready = m1;

    // stage 1: difference, trace, magnitudes
    logic        [DW-1:0]   dmag_reg;
    logic        [EW-1:0]   bmag_reg, cmag_reg;
    logic                   neg1_reg;
    logic signed [DW-1:0]   sum1_reg;
    logic signed [DW-1:0]   diff_next, sum_next;

    assign diff_next = DW'(a_in) - DW'(d_in);
    assign sum_next  = DW'(a_in) + DW'(d_in);

    always_ff @(posedge clk)
    begin
        if (m1 && s_tvalid)
        begin
            dmag_reg <= diff_next[DW-1] ? DW'(-diff_next) : DW'(diff_next);
            bmag_reg <= b_in[EW-1] ? EW'(-b_in) : EW'(b_in);
            cmag_reg <= c_in[EW-1] ? EW'(-c_in) : EW'(c_in);
            neg1_reg <= b_in[EW-1] ^ c_in[EW-1];
            sum1_reg <= sum_next;
        end
    end

    // stage 2: products
    logic        [PW-1:0]   p_reg;
    logic        [BW-1:0]   bc_reg;
    logic                   neg2_reg;
    logic signed [DW-1:0]   sum2_reg;

    always_ff @(posedge clk)
    begin
        if (m2 && v1_reg)
        begin
            p_reg    <= PW'(dmag_reg) * PW'(dmag_reg);
            bc_reg   <= BW'(bmag_reg) * BW'(cmag_reg);
            neg2_reg <= neg1_reg;
            sum2_reg <= sum1_reg;
        end
    end

    // stage 3: discriminant
    logic signed [SW-1:0]   disc_reg;
    logic signed [DW-1:0]   sum3_reg;
    logic        [SW-1:0]   q4_next;

    assign q4_next = SW'({bc_reg, 2'b00});

    always_ff @(posedge clk)
    begin
        if (m3 && v2_reg)
        begin
            disc_reg <= neg2_reg ? SW'(SW'(p_reg) - q4_next) : SW'(SW'(p_reg) + q4_next);
            sum3_reg <= sum2_reg;
        end
    end

    // square root pipeline: entry 0 holds |D|, entry j has resolved j root bits
    logic        [MW-1:0]   rem_reg  [0:RW];
    logic        [RW-1:0]   root_reg [0:RW];
    logic signed [DW-1:0]   sum_reg  [0:RW];
    logic                   cplx_reg [0:RW];

    always_ff @(posedge clk)
    begin
        if (ma[0] && v3_reg)
        begin
            rem_reg[0]  <= disc_reg[SW-1] ? MW'(-disc_reg) : MW'(disc_reg);
            root_reg[0] <= '0;
            sum_reg[0]  <= sum3_reg;
            cplx_reg[0] <= disc_reg[SW-1];
        end
    end

    generate
        for (g = 1; g <= RW; g++)
        begin : g_root
            localparam int K = RW - g;
            logic [TW-1:0] trial_next;
            logic          take_next;

            assign trial_next = (TW'(root_reg[g-1]) << (K + 1)) + (TW'(1) << (2 * K));
            assign take_next  = TW'(rem_reg[g-1]) >= trial_next;

            always_ff @(posedge clk)
            begin
                if (ma[g] && va_reg[g-1])
                begin
                    rem_reg[g]  <= take_next ? MW'(TW'(rem_reg[g-1]) - trial_next)
                                             : rem_reg[g-1];
                    root_reg[g] <= take_next ? (root_reg[g-1] | (RW'(1) << K))
                                             : root_reg[g-1];
                    sum_reg[g]  <= sum_reg[g-1];
                    cplx_reg[g] <= cplx_reg[g-1];
                end
            end
        end
    endgenerate

    // output register
    real_x2_t  fr_reg, sr_reg;
    imag_neg_t fi_reg;
    imag_pos_t si_reg;
    logic      cplx_o_reg;
    logic [OW-1:0] s_ext, r_ext;

    assign s_ext = OW'(sum_reg[RW]);
    assign r_ext = OW'(root_reg[RW]);

    always_ff @(posedge clk)
    begin
        if (mo && va_reg[RW])
        begin
            if (cplx_reg[RW])
            begin
                fr_reg <= s_ext[W_REAL-1:0];
                sr_reg <= s_ext[W_REAL-1:0];
                fi_reg <= W_IMAG_NEG'(OW'(0) - r_ext);
                si_reg <= r_ext[W_IMAG_POS-1:0];
            end
            else
            begin
                fr_reg <= W_REAL'(s_ext - r_ext);
                sr_reg <= W_REAL'(s_ext + r_ext);
                fi_reg <= '0;
                si_reg <= '0;
            end
            cplx_o_reg <= cplx_reg[RW];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int i = 0; i <= RW; i++)
            begin
                va_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (m1)
            begin
                v1_reg <= s_tvalid;
            end
            if (m2)
            begin
                v2_reg <= v1_reg;
            end
            if (m3)
            begin
                v3_reg <= v2_reg;
            end
            if (ma[0])
            begin
                va_reg[0] <= v3_reg;
            end
            for (int i = 1; i <= RW; i++)
            begin
                if (ma[i])
                begin
                    va_reg[i] <= va_reg[i-1];
                end
            end
            if (mo)
            begin
                vo_reg <= va_reg[RW];
            end
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tuser  = cplx_o_reg;
    assign m_tdata  = OUT_DATA_W'({si_reg, sr_reg, fi_reg, fr_reg});

    function automatic logic [W_REAL-1:0] s_out_mid();
        return W_REAL'((W_REAL + 1)'(fr_reg) + (W_REAL + 1)'(sr_reg) >>> 1);
    endfunction

    function automatic logic [W_REAL-1:0] r_out_ext();
        return W_REAL'(sr_reg - s_out_mid());
    endfunction

`ifndef ASSERT_OFF
    a_cplx_same_real: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> fr_reg == sr_reg)
        else $error("complex pair with differing real parts");

    a_real_no_imag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> fi_reg == '0 && si_reg == '0)
        else $error("real eigenvalues carry imaginary part");

    a_conj_imag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> fi_reg == W_IMAG_NEG'(-W_IMAG_NEG'(si_reg)))
        else $error("imaginary parts not conjugate");

    a_real_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> W_REAL'(sr_reg - fr_reg) == W_REAL'(2 * r_out_ext()))
        else $error("real spread differs from twice the root");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streaming regression for the 2x2 eigenvalue pipeline.
// ----------------------------------------------------------------------------
// Sends directed and random matrices through the slave port. Each accepted
// beat gets its eigenvalues worked out in integer arithmetic: the exact
// discriminant (a-d)^2+4bc and the floor square root of its magnitude. Each
// result beat is checked field by field, in order, against those values.
// Both ports idle in random bursts except near the end of the run.
module tb_top;
    import eig2_pkg::*;

    localparam int ENTRY_W      = 16;
    localparam int RANDOM_BEATS = 1730;
    localparam int CALM_BEATS   = 250;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SHOWN_ERRORS = 10;

    typedef struct {
        real_x2_t  first_real;
        imag_neg_t first_imag;
        real_x2_t  second_real;
        imag_pos_t second_imag;
        logic      is_complex;
    } eig_pair_t;

    class eig_scoreboard;
        eig_pair_t pending_eigs[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        function eig_pair_t eigen_of(logic [4*ENTRY_W-1:0] word);
            longint    a;
            longint    b;
            longint    c;
            longint    d;
            longint    trace;
            longint    disc;
            longint    mag;
            longint    root;
            longint    cand;
            eig_pair_t e;
            a     = longint'($signed(word[0*ENTRY_W +: ENTRY_W]));
            b     = longint'($signed(word[1*ENTRY_W +: ENTRY_W]));
            c     = longint'($signed(word[2*ENTRY_W +: ENTRY_W]));
            d     = longint'($signed(word[3*ENTRY_W +: ENTRY_W]));
            trace = a + d;
            disc  = (a - d) * (a - d) + 4 * b * c;
            mag   = (disc < 0) ? -disc : disc;
            root  = 0;
            for (int k = 17; k >= 0; k--)
            begin
                cand = root | (longint'(1) << k);
                if (cand * cand <= mag)
                    root = cand;
            end
            e.is_complex = (disc < 0);
            if (e.is_complex)
            begin
                e.first_real  = real_x2_t'(trace);
                e.second_real = real_x2_t'(trace);
                e.first_imag  = imag_neg_t'(-root);
                e.second_imag = imag_pos_t'(root);
            end
            else
            begin
                e.first_real  = real_x2_t'(trace - root);
                e.second_real = real_x2_t'(trace + root);
                e.first_imag  = '0;
                e.second_imag = '0;
            end
            return e;
        endfunction

        function void note_matrix(logic [4*ENTRY_W-1:0] word);
            pending_eigs.push_back(eigen_of(word));
        endfunction

        function void check_eigs(logic [OUT_DATA_W-1:0] word, logic flag);
            eig_pair_t got;
            eig_pair_t want;
            got.first_real  = word[0 +: W_REAL];
            got.first_imag  = word[W_REAL +: W_IMAG_NEG];
            got.second_real = word[W_REAL+W_IMAG_NEG +: W_REAL];
            got.second_imag = word[2*W_REAL+W_IMAG_NEG +: W_IMAG_POS];
            got.is_complex  = flag;
            if (pending_eigs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("ERROR: result beat with nothing pending: re %0d/%0d im %0d/%0d c %0b",
                             got.first_real, got.second_real, got.first_imag,
                             got.second_imag, got.is_complex);
                return;
            end
            want = pending_eigs.pop_front();
            if (got.first_real !== want.first_real || got.first_imag !== want.first_imag
                || got.second_real !== want.second_real
                || got.second_imag !== want.second_imag
                || got.is_complex !== want.is_complex)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("ERROR: expected re %0d/%0d im %0d/%0d c %0b, got re %0d/%0d im %0d/%0d c %0b",
                             want.first_real, want.second_real, want.first_imag,
                             want.second_imag, want.is_complex,
                             got.first_real, got.second_real, got.first_imag,
                             got.second_imag, got.is_complex);
            end
        endfunction

        function bit drained();
            return pending_eigs.size() == 0;
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [4*ENTRY_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;

    eig_scoreboard sb;
    bit            calm = 1'b0;
    int            idle_odds = 0;
    int            cycles = 0;

    eigenvalues_2x2 #(.ENTRY_WIDTH(ENTRY_W)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("eigenvalues_2x2 regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_matrix(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_eigs(m_tdata, m_tuser);
    end

    // stall the result side in bursts until the calm tail
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    task automatic send_matrix(input logic [ENTRY_W-1:0] a, input logic [ENTRY_W-1:0] b,
                               input logic [ENTRY_W-1:0] c, input logic [ENTRY_W-1:0] d);
        if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, c, b, a};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic logic [ENTRY_W-1:0] pick_entry();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return ENTRY_W'($urandom_range(0, 16) - 8);
            default: return ENTRY_W'($urandom);
        endcase
    endfunction

    task automatic send_random_matrix();
        int                 k;
        int                 lo;
        logic [ENTRY_W-1:0] a;
        logic [ENTRY_W-1:0] d;
        logic [ENTRY_W-1:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2:
                send_matrix(ENTRY_W'($urandom), ENTRY_W'($urandom),
                            ENTRY_W'($urandom), ENTRY_W'($urandom));
            3, 4:
                send_matrix(pick_entry(), pick_entry(), pick_entry(), pick_entry());
            5, 6:
            begin
                // opposite-sign off-diagonal, close diagonal: near the real/complex edge
                d = ENTRY_W'($urandom);
                a = d + ENTRY_W'($urandom_range(0, 64) - 32);
                b = ENTRY_W'($urandom_range(1, 32767));
                send_matrix(a, b, -ENTRY_W'($urandom_range(1, 32768)), d);
            end
            7, 8:
            begin
                // build a zero discriminant: a-d = 2k, b = k, c = -k
                k  = $urandom_range(0, 16383);
                lo = $urandom_range(0, 65535 - 2 * k) - 32768;
                send_matrix(ENTRY_W'(lo + 2 * k), ENTRY_W'(k), ENTRY_W'(-k), ENTRY_W'(lo));
            end
            default:
            begin
                b = pick_entry();
                send_matrix(pick_entry(), b, b, pick_entry());
            end
        endcase
    endtask

    initial
    begin
        sb = new();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_matrix(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_matrix(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_matrix(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_matrix(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF);
        send_matrix(16'h8000, 16'h0000, 16'h0000, 16'h8000);
        send_matrix(16'd5, 16'd0, -16'd7, 16'd5);
        send_matrix(16'd5, -16'd9, 16'd0, -16'd2);
        send_matrix(16'd0, 16'd1, -16'd1, 16'd0);
        send_matrix(16'd3, 16'd1, -16'd1, 16'd1);
        send_matrix(16'd10, 16'd2, -16'd3, 16'd0);
        send_matrix(16'd0, 16'h7FFF, 16'h8000, 16'd0);
        send_matrix(16'd0, 16'h8000, 16'h7FFF, 16'd0);
        send_matrix(16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
        send_matrix(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_matrix(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_matrix(16'd3, 16'd2, 16'd2, 16'd0);
        send_matrix(16'd2, 16'd1, 16'd1, 16'd0);
        send_matrix(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_matrix(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_matrix(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 50 == 0)
                idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
            if (n == RANDOM_BEATS - CALM_BEATS)
                calm = 1'b1;
            send_random_matrix();
        end
        s_tvalid <= 1'b0;

        while (!sb.drained())
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.drained())
            $display("eigenvalues_2x2 regression: pass");
        else
            $display("eigenvalues_2x2 regression: fail");
        $finish;
    end

endmodule

### eigenvalues_2x2.f
design/eig2_pkg.sv
design/eigenvalues_2x2.sv
tb/tb_top.sv
